// ===== rtl/core/page_replacement_policy_assert.svh =====
// assertion macros for the page replacement unit
`ifndef PAGE_REPLACEMENT_POLICY_ASSERT_SVH
`define PAGE_REPLACEMENT_POLICY_ASSERT_SVH
`ifndef SYNTHESIS
`define PRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PRP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PRP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PRP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/core/prp_pkg.sv =====
// shared types and constants of the page replacement unit
package prp_pkg;

  localparam int unsigned DEF_NUM_FRAMES = 8;
  localparam int unsigned DEF_PAGE_BITS  = 16;

  localparam int unsigned AGE_W    = 16;
  localparam int unsigned USE_W    = 16;
  localparam int unsigned HIT_W    = 16;
  localparam int unsigned FRAME_W  = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned FIU_W    = 4;
  localparam int unsigned MCOUNT_W = 8;

  localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LRU  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LFU  = 2'd2;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // token that walks the chain, one cell per cycle
  typedef struct packed {
    logic             hit;
    logic             free;
    logic             best_set;
    logic [USE_W-1:0] best_uses;
    logic [AGE_W-1:0] best_age;
  } tok_t;

  // broadcast from the sequencer to all cells
  typedef struct packed {
    logic commit;
    logic hit;
    logic lru;
    logic lfu;
    logic clear;
  } cmd_t;

endpackage

// ===== rtl/core/prp_cell.sv =====
// one frame cell: holds a frame's state and merges it into the passing token
module prp_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 managed,
  input  logic [PAGE_BITS-1:0] req_page,
  input  prp_pkg::tok_t        tok_in,
  input  logic [IDX_W-1:0]     hit_idx_in,
  input  logic [IDX_W-1:0]     free_idx_in,
  input  logic [IDX_W-1:0]     best_idx_in,
  input  logic [PAGE_BITS-1:0] best_page_in,
  output prp_pkg::tok_t        tok_out,
  output logic [IDX_W-1:0]     hit_idx_out,
  output logic [IDX_W-1:0]     free_idx_out,
  output logic [IDX_W-1:0]     best_idx_out,
  output logic [PAGE_BITS-1:0] best_page_out,
  input  prp_pkg::cmd_t        cmd,
  input  logic [IDX_W-1:0]     slot
);
  import prp_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic [AGE_W-1:0]     age;
  logic [USE_W-1:0]     uses;

  logic [PAGE_BITS-1:0] page_next;
  logic                 valid_next;
  logic [AGE_W-1:0]     age_next;
  logic [USE_W-1:0]     uses_next;

  tok_t                 tok_next;
  logic [IDX_W-1:0]     hit_idx_next;
  logic [IDX_W-1:0]     free_idx_next;
  logic [IDX_W-1:0]     best_idx_next;
  logic [PAGE_BITS-1:0] best_page_next;
  logic                 take;

  // token merge
  always_comb begin
    tok_next       = tok_in;
    hit_idx_next   = hit_idx_in;
    free_idx_next  = free_idx_in;
    best_idx_next  = best_idx_in;
    best_page_next = best_page_in;
    take           = 1'b0;
    if (managed) begin
      if (!tok_in.hit && valid && (page == req_page)) begin
        tok_next.hit = 1'b1;
        hit_idx_next = MY_IDX;
      end
      if (!tok_in.free && !valid) begin
        tok_next.free = 1'b1;
        free_idx_next = MY_IDX;
      end
      if (!tok_in.best_set) begin
        take = 1'b1;
      end else if (cmd.lfu) begin
        take = (uses < tok_in.best_uses) ||
               ((uses == tok_in.best_uses) && (age > tok_in.best_age));
      end else begin
        take = age > tok_in.best_age;
      end
      if (take) begin
        tok_next.best_set  = 1'b1;
        tok_next.best_uses = uses;
        tok_next.best_age  = age;
        best_idx_next      = MY_IDX;
        best_page_next     = page;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_out       <= tok_next;
    hit_idx_out   <= hit_idx_next;
    free_idx_out  <= free_idx_next;
    best_idx_out  <= best_idx_next;
    best_page_out <= best_page_next;
  end

  // frame update at commit
  always_comb begin
    page_next  = page;
    valid_next = valid;
    age_next   = age;
    uses_next  = uses;
    if (cmd.commit && managed) begin
      if (slot == MY_IDX) begin
        if (cmd.hit) begin
          if (cmd.lru) begin
            age_next = '0;
          end
          if (cmd.lfu && (uses != '1)) begin
            uses_next = uses + USE_W'(1);
          end
        end else begin
          page_next  = req_page;
          valid_next = 1'b1;
          age_next   = '0;
          uses_next  = USE_W'(1);
        end
      end
      if (valid_next && (age_next != '1)) begin
        age_next = age_next + AGE_W'(1);
      end
    end
    if (cmd.commit && cmd.clear) begin
      valid_next = 1'b0;
      age_next   = '0;
      uses_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      age   <= '0;
      uses  <= '0;
    end else begin
      valid <= valid_next;
      age   <= age_next;
      uses  <= uses_next;
    end
  end

  always_ff @(posedge clk) begin
    page <= page_next;
  end

endmodule

// ===== rtl/core/page_replacement_policy.sv =====
// top level of the page replacement unit: sequencer, cell chain and result register
//
// Page replacement unit with FIFO, LRU and LFU policies over NUM_FRAMES frames. Each request
// (one page access) is accepted in the idle state. A search token then walks the row of frame
// cells one cell per cycle, collecting the matching frame, the first free frame and the
// replacement candidate. The commit state then commits the update to all cells and loads the
// result register, and the unit returns to idle, where the next request is taken. The result
// waits in its own register, so a new request is taken while it is still pending; a commit
// waits only if the previous result has not yet been taken. Configuration writes take effect
// at once and are meant to be made while no request is in flight.
`include "page_replacement_policy_assert.svh"

module page_replacement_policy #(
  parameter int unsigned NUM_FRAMES = prp_pkg::DEF_NUM_FRAMES,
  parameter int unsigned PAGE_BITS  = prp_pkg::DEF_PAGE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [prp_pkg::FIU_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [PAGE_BITS-1:0]          page,
  input  logic                          last_access,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [prp_pkg::FRAME_W-1:0]   frame,
  output logic                          evicted_valid,
  output logic [PAGE_BITS-1:0]          evicted_page,
  output logic [prp_pkg::HIT_W-1:0]     hit_total
);
  import prp_pkg::*;

  localparam int unsigned IDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

  state_t state, state_next;
  logic [IDX_W-1:0]     cnt, cnt_next;
  logic [PAGE_BITS-1:0] req_page;
  logic                 req_last;
  logic [MODE_W-1:0]    mode;
  logic [FIU_W-1:0]     frames_in_use;
  logic [HIT_W-1:0]     hit_count, hit_count_next, hit_inc;

  logic [MCOUNT_W-1:0]  fiu_ext;
  logic [MCOUNT_W-1:0]  n_eff;
  logic [NUM_FRAMES-1:0] managed;

  tok_t                 tok_link       [NUM_FRAMES];
  logic [IDX_W-1:0]     hit_idx_link   [NUM_FRAMES];
  logic [IDX_W-1:0]     free_idx_link  [NUM_FRAMES];
  logic [IDX_W-1:0]     best_idx_link  [NUM_FRAMES];
  logic [PAGE_BITS-1:0] best_page_link [NUM_FRAMES];

  tok_t                 tok_fin;
  cmd_t                 cmd;
  logic [IDX_W-1:0]     slot;
  logic                 do_commit;
  logic                 ev_sel;
  logic [IDX_W+FRAME_W-1:0] slot_wide;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_FIFO;
      frames_in_use <= FIU_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   mode          <= cfg_data[MODE_W-1:0];
        REG_FRAMES: frames_in_use <= cfg_data;
        default:    ;
      endcase
    end
  end

  // managed range clamps to 1 .. NUM_FRAMES
  always_comb begin
    fiu_ext = MCOUNT_W'(frames_in_use);
    if (fiu_ext == '0) begin
      n_eff = MCOUNT_W'(1);
    end else if (fiu_ext > MCOUNT_W'(NUM_FRAMES)) begin
      n_eff = MCOUNT_W'(NUM_FRAMES);
    end else begin
      n_eff = fiu_ext;
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_page <= page;
      req_last <= last_access;
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign tok_fin  = tok_link[NUM_FRAMES-1];
  assign do_commit = (state == ST_COMMIT) && (!out_valid || out_ready);

  always_comb begin
    if (tok_fin.hit) begin
      slot = hit_idx_link[NUM_FRAMES-1];
    end else if (tok_fin.free) begin
      slot = free_idx_link[NUM_FRAMES-1];
    end else begin
      slot = best_idx_link[NUM_FRAMES-1];
    end
  end

  assign ev_sel    = !tok_fin.hit && !tok_fin.free;
  assign slot_wide = (IDX_W+FRAME_W)'(slot);
  assign hit_inc   = (hit_count != '1) ? hit_count + HIT_W'(1) : hit_count;

  assign cmd.commit = do_commit;
  assign cmd.hit    = tok_fin.hit;
  assign cmd.lru    = (mode == MODE_LRU);
  assign cmd.lfu    = (mode == MODE_LFU);
  assign cmd.clear  = req_last;

  // sequencer
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    hit_count_next = hit_count;
    unique case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == IDX_W'(NUM_FRAMES - 1)) begin
          state_next = ST_COMMIT;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end
      ST_COMMIT: begin
        if (do_commit) begin
          state_next = ST_IDLE;
          if (req_last) begin
            hit_count_next = '0;
          end else if (tok_fin.hit) begin
            hit_count_next = hit_inc;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      hit_count <= '0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      hit_count <= hit_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_commit) begin
      hit           <= tok_fin.hit;
      frame         <= slot_wide[FRAME_W-1:0];
      evicted_valid <= ev_sel;
      evicted_page  <= ev_sel ? best_page_link[NUM_FRAMES-1] : '0;
      hit_total     <= tok_fin.hit ? hit_inc : hit_count;
    end
  end

  // row of frame cells
  for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
    tok_t                 tok_in;
    logic [IDX_W-1:0]     hit_idx_in;
    logic [IDX_W-1:0]     free_idx_in;
    logic [IDX_W-1:0]     best_idx_in;
    logic [PAGE_BITS-1:0] best_page_in;

    assign managed[i] = n_eff > MCOUNT_W'(i);

    if (i == 0) begin : g_head
      assign tok_in       = '0;
      assign hit_idx_in   = '0;
      assign free_idx_in  = '0;
      assign best_idx_in  = '0;
      assign best_page_in = '0;
    end else begin : g_link
      assign tok_in       = tok_link[i-1];
      assign hit_idx_in   = hit_idx_link[i-1];
      assign free_idx_in  = free_idx_link[i-1];
      assign best_idx_in  = best_idx_link[i-1];
      assign best_page_in = best_page_link[i-1];
    end

    prp_cell #(
      .IDX       (i),
      .IDX_W     (IDX_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .managed       (managed[i]),
      .req_page      (req_page),
      .tok_in        (tok_in),
      .hit_idx_in    (hit_idx_in),
      .free_idx_in   (free_idx_in),
      .best_idx_in   (best_idx_in),
      .best_page_in  (best_page_in),
      .tok_out       (tok_link[i]),
      .hit_idx_out   (hit_idx_link[i]),
      .free_idx_out  (free_idx_link[i]),
      .best_idx_out  (best_idx_link[i]),
      .best_page_out (best_page_link[i]),
      .cmd           (cmd),
      .slot          (slot)
    );
  end

  `PRP_ASSERT_NXT(a_accept_starts_scan, clk, rst, in_valid && in_ready,
                  (state == ST_SCAN) && (cnt == '0), "accepted request did not start the scan")
  `PRP_ASSERT_NXT(a_commit_holds, clk, rst, (state == ST_COMMIT) && out_valid && !out_ready,
                  state == ST_COMMIT, "commit overran a pending result")
  `PRP_ASSERT_IMP(a_hit_no_evict, clk, rst, out_valid, !(hit && evicted_valid),
                  "result shows both hit and eviction")
  `PRP_ASSERT_IMP(a_hit_counted, clk, rst, out_valid && hit, hit_total != '0,
                  "hit result with zero hit total")

endmodule
